### rtl/vn2d_pkg.sv
// Shared types, constants and helper functions for the 2-D value noise evaluator.
package vn2d_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned BANKS    = 4;
  localparam int unsigned BANK_SEL_W = 2;
  localparam int unsigned BANK_AW  = IDX_W - BANK_SEL_W;
  localparam int unsigned EASE_W   = 18;
  localparam int unsigned PROD_W   = 2 * (VAL_W + 1);

  // 3.0 in Q16 for the smoothstep factor (3 - 2t)
  localparam logic [EASE_W-1:0] THREE_Q16 = 18'h30000;
  localparam logic [VAL_W-1:0]  VAL_MAX   = 16'hFFFF;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_EVAL  = 1'b1
  } kind_t;

  typedef logic [BANK_AW-1:0] bank_addr_t;
  typedef logic [VAL_W-1:0]   val_t;

  // Lattice memory request: one write and four bank reads, issued on ld.
  typedef struct packed {
    logic                       ld;
    logic                       wr_en;
    logic [BANK_SEL_W-1:0]      wr_bank;
    bank_addr_t                 wr_addr;
    val_t                       wr_data;
    logic [BANKS-1:0][BANK_AW-1:0] rd_addr;
  } lat_req_t;

  // Stage loads for the two-stage ease unit.
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } ease_ctl_t;

  // Bank select: row parity sits at bit g, column parity at bit 0.
  function automatic logic [BANK_SEL_W-1:0] bank_sel(logic [IDX_W-1:0] a, int unsigned g);
    logic [BANK_SEL_W-1:0] s;
    s = {a[g], a[0]};
    return s;
  endfunction

  // In-bank address: drop bits g and 0 from the table address.
  function automatic bank_addr_t bank_addr(logic [IDX_W-1:0] a, int unsigned g);
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] lo_mask;
    lo_mask = (IDX_W'(1) << (g - 1)) - IDX_W'(1);
    hi = (a >> (g + 1)) << (g - 1);
    lo = (a >> 1) & lo_mask;
    return BANK_AW'(hi | lo);
  endfunction

endpackage

### rtl/vn2d_in_if.sv
// Input channel of the value noise evaluator: valid/ready plus one item.
interface vn2d_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic [15:0]        entry_index;
  logic [15:0]        entry_value;

  modport source (output valid, kind, x_coord, y_coord, entry_index, entry_value,
                  input ready);
  modport sink   (input valid, kind, x_coord, y_coord, entry_index, entry_value,
                  output ready);
endinterface

### rtl/vn2d_out_if.sv
// Result channel of the value noise evaluator: valid/ready plus one noise value.
interface vn2d_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

### rtl/vn2d_ease.sv
// Two-stage smoothstep unit: s = t*t*(3-2t) in truncating Q0.16.
module vn2d_ease
  import vn2d_pkg::*;
(
  input  logic       clk,
  input  ease_ctl_t  ctl,
  input  val_t       t,
  output val_t       s
);

  val_t              tt_r;
  val_t              t_r;
  val_t              s_r;
  logic [2*VAL_W-1:0] sq;
  logic [EASE_W-1:0]  fac;
  logic [VAL_W+EASE_W-1:0] prod;
  logic [EASE_W-1:0]  s_wide;
  val_t              s_nxt;

  assign sq = {{VAL_W{1'b0}}, t} * {{VAL_W{1'b0}}, t};

  // t*t in Q16, held with t for the second product
  always_ff @(posedge clk) begin
    if (ctl.ld_a) begin
      tt_r <= sq[2*VAL_W-1:FRAC_W];
      t_r  <= t;
    end
  end

  always_comb begin
    fac    = THREE_Q16 - {1'b0, t_r, 1'b0};
    prod   = {{EASE_W{1'b0}}, tt_r} * {{VAL_W{1'b0}}, fac};
    s_wide = prod[FRAC_W +: EASE_W];
    // clamp to the largest Q0.16 value
    s_nxt  = (|s_wide[EASE_W-1:VAL_W]) ? VAL_MAX : s_wide[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_b) begin
      s_r <= s_nxt;
    end
  end

  assign s = s_r;

endmodule

### rtl/vn2d_lattice.sv
// Lattice table split into four parity banks, one write and four reads per cycle while req.ld is high.
module vn2d_lattice
  import vn2d_pkg::*;
(
  input  logic                      clk,
  input  lat_req_t                  req,
  output logic [BANKS-1:0][VAL_W-1:0] rd_data
);

  localparam int unsigned BANK_DEPTH = 1 << BANK_AW;

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    val_t mem [BANK_DEPTH];
    val_t rd_r;

    // write and read on the same stage advance, read data registered
    always_ff @(posedge clk) begin
      if (req.ld) begin
        if (req.wr_en && (req.wr_bank == BANK_SEL_W'(b))) begin
          mem[req.wr_addr] <= req.wr_data;
        end
        rd_r <= mem[req.rd_addr[b]];
      end
    end

    assign rd_data[b] = rd_r;
  end

endmodule

### rtl/value_noise_2d_eval.sv
// Top level of the pipelined 2-D value noise evaluator over a wrapping lattice.
//
// Usage: one input channel (in_ch) and one result channel (out_ch), both
// valid/ready; an item moves at a clock edge where valid and ready are high.
// A write item (kind = 0) stores entry_value at entry_index in the lattice
// table and gives no result. An evaluate item (kind = 1) takes signed Q16.16
// x_coord and y_coord and gives one unsigned Q0.16 noise_value.
// Throughput: one item per cycle while the receiver does not stall, writes and evaluates mixed freely.
// An item passes six register stages on its way to a valid result (corner
// addressing and t*t, bank read and ease, x products, x sums, y product,
// output register).
// The table is four parity banks (row and column parity), so the four corner
// reads of one point go to four different banks in the same cycle; writes are
// done in the same stage as reads, so item order holds for table contents.
// Reset clears only the stage valid bits; table contents are undefined until
// written. When the receiver stalls, the result holds in the output register
// and earlier stages keep filling bubbles, so in_ch.ready drops only when
// every stage holds an item.
module value_noise_2d_eval
  import vn2d_pkg::*;
#(
  parameter int unsigned GRID_LOG2 = 8
)(
  input  logic          clk,
  input  logic          rst_n,
  vn2d_in_if.sink       in_ch,
  vn2d_out_if.source    out_ch
);

  // ---------------- stage load chain ----------------
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, out_v_r;
  logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_out;

  assign ld_out = !out_v_r || out_ch.ready;
  assign ld_e   = !v_e_r   || ld_out;
  assign ld_d   = !v_d_r   || ld_e;
  assign ld_c   = !v_c_r   || ld_d;
  assign ld_b   = !v_b_r   || ld_c;
  assign ld_a   = !v_a_r   || ld_b;

  assign in_ch.ready = ld_a;

  // ---------------- stage A: corner addressing ----------------
  logic [GRID_LOG2-1:0] x0, x1, y0, y1;
  logic [BANKS-1:0][BANK_AW-1:0] rd_addr_nxt;

  assign x0 = in_ch.x_coord[FRAC_W +: GRID_LOG2];
  assign y0 = in_ch.y_coord[FRAC_W +: GRID_LOG2];
  assign x1 = x0 + GRID_LOG2'(1);
  assign y1 = y0 + GRID_LOG2'(1);

  // Each bank holds one row/column parity; pick the corner that lands there.
  always_comb begin
    logic [BANK_SEL_W-1:0] bsel;
    logic [GRID_LOG2-1:0]  row;
    logic [GRID_LOG2-1:0]  col;
    logic [IDX_W-1:0]      addr;
    for (int b = 0; b < BANKS; b++) begin
      bsel = BANK_SEL_W'(b);
      row  = (y0[0] == bsel[1]) ? y0 : y1;
      col  = (x0[0] == bsel[0]) ? x0 : x1;
      addr = (IDX_W'(row) << GRID_LOG2) | IDX_W'(col);
      rd_addr_nxt[b] = bank_addr(addr, GRID_LOG2);
    end
  end

  logic                          kind_a_r;
  logic                          xp_a_r, yp_a_r;
  logic [BANKS-1:0][BANK_AW-1:0] rd_addr_a_r;
  logic [BANK_SEL_W-1:0]         wr_bank_a_r;
  bank_addr_t                    wr_addr_a_r;
  val_t                          wr_data_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (ld_a) begin
      v_a_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      kind_a_r    <= in_ch.kind;
      xp_a_r      <= x0[0];
      yp_a_r      <= y0[0];
      rd_addr_a_r <= rd_addr_nxt;
      wr_bank_a_r <= bank_sel(in_ch.entry_index, GRID_LOG2);
      wr_addr_a_r <= bank_addr(in_ch.entry_index, GRID_LOG2);
      wr_data_a_r <= in_ch.entry_value;
    end
  end

  // ---------------- stage B: table read and ease ----------------
  ease_ctl_t                   ease_ctl;
  lat_req_t                    lat_req;
  logic [BANKS-1:0][VAL_W-1:0] bank_q;
  val_t                        sx_b, sy_b;
  logic                        is_write_a;

  assign ease_ctl.ld_a = ld_a;
  assign ease_ctl.ld_b = ld_b;
  assign is_write_a    = v_a_r && (kind_a_r == KIND_WRITE);

  assign lat_req.ld      = ld_b;
  assign lat_req.wr_en   = is_write_a;
  assign lat_req.wr_bank = wr_bank_a_r;
  assign lat_req.wr_addr = wr_addr_a_r;
  assign lat_req.wr_data = wr_data_a_r;
  assign lat_req.rd_addr = rd_addr_a_r;

  vn2d_lattice u_lattice (
    .clk     (clk),
    .req     (lat_req),
    .rd_data (bank_q)
  );

  vn2d_ease u_ease_x (
    .clk (clk),
    .ctl (ease_ctl),
    .t   (in_ch.x_coord[FRAC_W-1:0]),
    .s   (sx_b)
  );

  vn2d_ease u_ease_y (
    .clk (clk),
    .ctl (ease_ctl),
    .t   (in_ch.y_coord[FRAC_W-1:0]),
    .s   (sy_b)
  );

  logic xp_b_r, yp_b_r;

  // Drop write items here: they finish with the table write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (ld_b) begin
      v_b_r <= v_a_r && (kind_a_r == KIND_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      xp_b_r <= xp_a_r;
      yp_b_r <= yp_a_r;
    end
  end

  // ---------------- stage C: x-direction products ----------------
  // lerp(a, b, s) = a + floor((b - a) * s / 2^16), exact for the blend form
  val_t                     c00, c10, c01, c11;
  logic signed [VAL_W:0]    d0, d1;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt;

  always_comb begin
    c00 = bank_q[{yp_b_r,  xp_b_r}];
    c10 = bank_q[{yp_b_r, ~xp_b_r}];
    c01 = bank_q[{~yp_b_r,  xp_b_r}];
    c11 = bank_q[{~yp_b_r, ~xp_b_r}];
    d0  = $signed({1'b0, c10}) - $signed({1'b0, c00});
    d1  = $signed({1'b0, c11}) - $signed({1'b0, c01});
    p0_nxt = d0 * $signed({1'b0, sx_b});
    p1_nxt = d1 * $signed({1'b0, sx_b});
  end

  logic signed [PROD_W-1:0] p0_c_r, p1_c_r;
  val_t                     c00_c_r, c01_c_r, sy_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (ld_c) begin
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_c) begin
      p0_c_r  <= p0_nxt;
      p1_c_r  <= p1_nxt;
      c00_c_r <= c00;
      c01_c_r <= c01;
      sy_c_r  <= sy_b;
    end
  end

  // ---------------- stage D: x-direction sums ----------------
  logic signed [VAL_W+1:0] n0_sum, n1_sum;

  assign n0_sum = $signed({2'b00, c00_c_r}) + p0_c_r[PROD_W-1:FRAC_W];
  assign n1_sum = $signed({2'b00, c01_c_r}) + p1_c_r[PROD_W-1:FRAC_W];

  val_t n0_d_r, n1_d_r, sy_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= 1'b0;
    end else if (ld_d) begin
      v_d_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_d) begin
      n0_d_r <= n0_sum[VAL_W-1:0];
      n1_d_r <= n1_sum[VAL_W-1:0];
      sy_d_r <= sy_c_r;
    end
  end

  // ---------------- stage E: y-direction product ----------------
  logic signed [VAL_W:0]    dy;
  logic signed [PROD_W-1:0] py_nxt;

  assign dy     = $signed({1'b0, n1_d_r}) - $signed({1'b0, n0_d_r});
  assign py_nxt = dy * $signed({1'b0, sy_d_r});

  logic signed [PROD_W-1:0] py_e_r;
  val_t                     n0_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
    end else if (ld_e) begin
      v_e_r <= v_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_e) begin
      py_e_r <= py_nxt;
      n0_e_r <= n0_d_r;
    end
  end

  // ---------------- output register ----------------
  logic signed [VAL_W+1:0] noise_sum;
  val_t                    noise_r;

  assign noise_sum = $signed({2'b00, n0_e_r}) + py_e_r[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld_out) begin
      out_v_r <= v_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      noise_r <= noise_sum[VAL_W-1:0];
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.noise_value = noise_r;

  // ---------------- assertions ----------------
  // An unstalled output lets the whole pipe advance, so input is open.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_v_r || out_ch.ready) |-> in_ch.ready)
    else $error("input not ready while output side is free");

  // A write item leaves the pipe at the table write and never reaches stage C.
  a_write_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_b && is_write_a) |=> !v_b_r)
    else $error("write item passed the table stage");

  // A finished evaluate moves into an empty output register at once.
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (v_e_r && !out_v_r) |=> out_v_r)
    else $error("result not moved into empty output register");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the 2-D value noise evaluator: lattice fill, directed corners, random mix.
module testbench;
  import vn2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID_LOG2   = 8;
  localparam int unsigned TABLE_DEPTH = 65536;
  // Written band of rows and columns: 252..255 and 0..3. Evaluates stay on
  // cells whose four corners lie inside it.
  localparam int unsigned BAND_LO     = 252;
  localparam int unsigned BAND_SIZE   = 8;
  // About 650 items; with every gap and every stall at its longest, this is
  // still several times the longest run.
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  vn2d_in_if  in_ch();
  vn2d_out_if out_ch();

  value_noise_2d_eval #(
    .GRID_LOG2(GRID_LOG2)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the lattice table and the noise values still owed by the block.
  logic [15:0] lattice_mirror [0:TABLE_DEPTH-1];
  logic [15:0] noise_expected_q [$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_en;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Noise predictor
  // ---------------------------------------------------------------------------

  // Smoothstep t*t*(3-2t) in Q0.16, truncating, clamped to the top code.
  function automatic logic [15:0] smooth_ease(logic [15:0] t);
    logic [63:0] tt;
    logic [63:0] s;
    tt = (64'(t) * 64'(t)) >> 16;
    s  = (tt * (64'd196608 - 64'd2 * 64'(t))) >> 16;
    if (s > 64'h0000_FFFF) begin
      s = 64'h0000_FFFF;
    end
    return s[15:0];
  endfunction

  // Lerp a -> b by s, Q0.16, truncating toward minus infinity.
  function automatic logic [15:0] mix_q16(logic [15:0] a, logic [15:0] b, logic [15:0] s);
    logic [63:0] acc;
    acc = 64'(a) * (64'd65536 - 64'(s)) + 64'(b) * 64'(s);
    return acc[31:16];
  endfunction

  // Lattice address wraps to 16 bits, so large grids alias rows.
  function automatic logic [15:0] lattice_at(logic [31:0] row, logic [31:0] col);
    logic [31:0] addr;
    addr = (row << (GRID_LOG2 % 16)) | col;
    return lattice_mirror[addr[15:0]];
  endfunction

  function automatic logic [15:0] noise_at(logic [31:0] x, logic [31:0] y);
    logic [31:0] mask;
    logic [31:0] col0;
    logic [31:0] col1;
    logic [31:0] row0;
    logic [31:0] row1;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] upper;
    logic [15:0] lower;
    mask  = (32'd1 << (GRID_LOG2 % 16)) - 32'd1;
    col0  = (x >> 16) & mask;
    col1  = (col0 + 32'd1) & mask;
    row0  = (y >> 16) & mask;
    row1  = (row0 + 32'd1) & mask;
    sx    = smooth_ease(x[15:0]);
    sy    = smooth_ease(y[15:0]);
    upper = mix_q16(lattice_at(row0, col0), lattice_at(row0, col1), sx);
    lower = mix_q16(lattice_at(row1, col0), lattice_at(row1, col1), sx);
    return mix_q16(upper, lower, sy);
  endfunction

  // Random row or column inside the written band; span 7 keeps the +1 corner
  // inside the band as well.
  function automatic logic [7:0] band_coord(input int unsigned span);
    return 8'(BAND_LO + $urandom_range(0, span - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: all changes land on the falling edge
  // ---------------------------------------------------------------------------

  task automatic release_input();
    in_ch.valid <= 1'b0;
  endtask

  // Present one item and hold it until accepted. Return at the next falling
  // edge with valid still high, so a following item keeps valid asserted
  // with a single assignment in that step.
  task automatic send_item(input kind_t k, input logic [31:0] x, input logic [31:0] y,
                           input logic [15:0] idx, input logic [15:0] val);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.x_coord     <= x;
    in_ch.y_coord     <= y;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Accepted at this edge: advance the mirror in item order.
    if (k == KIND_WRITE) begin
      lattice_mirror[idx] = val;
    end else begin
      noise_expected_q.push_back(noise_at(x, y));
    end
    @(negedge clk);
  endtask

  // Unused fields carry random garbage; the block must ignore them.
  task automatic write_entry(input logic [15:0] idx, input logic [15:0] val);
    send_item(KIND_WRITE, $urandom, $urandom, idx, val);
  endtask

  task automatic eval_point(input logic [31:0] x, input logic [31:0] y);
    send_item(KIND_EVAL, x, y, 16'($urandom), 16'($urandom));
  endtask

  // Hold the input off until every owed result has come back.
  task automatic wait_for_drain();
    release_input();
    while (noise_expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on ready, checks at the rising edge
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned stall_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    $display("mismatch @%0t: %s got %04h expected %04h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (noise_expected_q.size() == 0) begin
        report_mismatch("noise_value with no evaluate pending", out_ch.noise_value, 16'h0);
      end else begin
        want = noise_expected_q.pop_front();
        if (out_ch.noise_value !== want) begin
          report_mismatch("noise_value", out_ch.noise_value, want);
        end
      end
    end
  end

  // Watchdog: a hung pipeline or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Write every entry of the band so no evaluate can touch an unwritten one.
  // Mix in the extreme codes.
  task automatic test_fill_lattice();
    int unsigned sel;
    logic [15:0] val;
    logic [15:0] idx;
    idle_en = 1'b0;
    for (int r = 0; r < BAND_SIZE; r++) begin
      for (int c = 0; c < BAND_SIZE; c++) begin
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
          val = 16'h0000;
        end else if (sel == 1) begin
          val = 16'hFFFF;
        end else begin
          val = 16'($urandom);
        end
        idx = {8'(BAND_LO + r), 8'(BAND_LO + c)};
        write_entry(idx, val);
      end
    end
  endtask

  // Corner values, fraction extremes, negative wrap and back-to-back
  // write-then-read of the same cell.
  task automatic test_corner_cases();
    idle_en = 1'b0;
    // Checkerboard cell at the origin.
    write_entry(16'h0000, 16'hFFFF);
    write_entry(16'h0001, 16'h0000);
    write_entry(16'h0100, 16'h0000);
    write_entry(16'h0101, 16'hFFFF);
    eval_point(32'h0000_0000, 32'h0000_0000);
    eval_point(32'h0000_8000, 32'h0000_8000);
    eval_point(32'h0000_FFFF, 32'h0000_FFFF);
    eval_point(32'h0000_4000, 32'h0000_C000);
    // Cells that wrap across the last row and column.
    write_entry(16'hFFFF, 16'hFFFF);
    write_entry(16'hFF00, 16'h0000);
    write_entry(16'h00FF, 16'h0000);
    eval_point(32'hFFFF_8000, 32'hFFFF_8000);  // floor(-0.5) -> last column
    eval_point(32'h00FF_0000, 32'h00FF_0000);
    eval_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_point(32'h8000_0000, 32'h8000_0000);
    eval_point(32'hFFFF_FFFF, 32'h0000_0000);
    eval_point(32'h0000_0000, 32'hFFFF_FFFF);
    eval_point(32'h0100_0000, 32'hFF00_0000);  // integer bits above the mask
    // Flat top cell: every blend must stay at the top code.
    write_entry(16'h0000, 16'hFFFF);
    write_entry(16'h0001, 16'hFFFF);
    write_entry(16'h0100, 16'hFFFF);
    write_entry(16'h0101, 16'hFFFF);
    eval_point(32'h0000_8000, 32'h0000_4000);
    // Read right behind the write to the same entry.
    write_entry(16'h0000, 16'h1234);
    eval_point(32'h0000_0000, 32'h0000_0000);
    wait_for_drain();
  endtask

  task automatic random_item();
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] val;
    if ($urandom_range(0, 1) == 0) begin
      val = 16'($urandom);
      case ($urandom_range(0, 7))
        0: val = 16'h0000;
        1: val = 16'hFFFF;
        default: ;
      endcase
      write_entry({band_coord(BAND_SIZE), band_coord(BAND_SIZE)}, val);
    end else begin
      x = $urandom;
      y = $urandom;
      // Keep the cell inside the written band; higher integer bits stay random.
      x[23:16] = band_coord(BAND_SIZE - 1);
      y[23:16] = band_coord(BAND_SIZE - 1);
      case ($urandom_range(0, 7))
        0: begin
          x[15:0] = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
          y[15:0] = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        end
        1: begin
          // Just below zero on both axes.
          x = -32'($urandom_range(1, 32'h0002_0000));
          y = -32'($urandom_range(1, 32'h0002_0000));
        end
        default: ;
      endcase
      eval_point(x, y);
    end
  endtask

  // Random writes and evaluates with idling on both sides and one full
  // drain in the middle.
  task automatic test_random_mix(input int unsigned count);
    idle_en = 1'b1;
    for (int unsigned i = 0; i < count; i++) begin
      random_item();
      if (i == count / 2) begin
        wait_for_drain();
      end
    end
  endtask

  // Back-to-back traffic at full rate to close the run.
  task automatic test_quiet_tail(input int unsigned count);
    idle_en = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      random_item();
    end
  endtask

  initial begin
    idle_en           = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_WRITE;
    in_ch.x_coord     = '0;
    in_ch.y_coord     = '0;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_fill_lattice();
    test_corner_cases();
    test_random_mix(400);
    test_quiet_tail(160);

    // Drop valid, drain, then let the pipeline run on idle so a stray result would be caught.
    release_input();
    while (noise_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/vn2d_pkg.sv
rtl/vn2d_in_if.sv
rtl/vn2d_out_if.sv
rtl/vn2d_ease.sv
rtl/vn2d_lattice.sv
rtl/value_noise_2d_eval.sv
tb/sv/testbench.sv
